@@ rtl/bsd_pkg.sv @@
// Package for the byte-stuffing deframer: register indexes, config and
// command structs, back-end state type and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;   // max_raw_length register and frame byte counts
  localparam int CFG_IDX_W = 3;

  localparam logic [BYTE_W-1:0] ESC_OFFSET = 8'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RAW_LEN = 3'd4;

  localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'd2;
  localparam logic [BYTE_W-1:0] RST_STOP_CODE   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'd27;
  localparam logic [LEN_W-1:0]  RST_MAX_RAW_LEN = 7'd64;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] stop_code;
    logic [BYTE_W-1:0] escape_code;
    logic              id_enable;
    logic [LEN_W-1:0]  max_raw_length;
  } bsd_cfg_t;

  // One good frame handed from the front to the back.
  typedef struct packed {
    logic [LEN_W-1:0] count;   // decoded bytes in the store, id included
    logic             id_en;
  } bsd_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_ID,
    BK_EMIT
  } bsd_back_state_t;

endpackage

`default_nettype wire

@@ rtl/bsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/bsd_front.sv @@
// Front end: tracks frame state per received byte, writes decoded bytes
// into the payload RAM and issues a command for every good frame (that has an id byte when id_enable is set).
// Depends on bsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsd_front #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bsd_pkg::bsd_cfg_t            cfg,
  input  wire logic                         accept,
  input  wire logic [bsd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                              ram_we,
  output logic [$clog2(MAX_FRAME)-1:0]      ram_waddr,
  output logic [bsd_pkg::BYTE_W-1:0]        ram_wdata,
  output logic                              cmd_push,
  output bsd_pkg::bsd_cmd_t                 cmd
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int AW    = $clog2(MAX_FRAME);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

  logic             frame_open_r, frame_open_nxt;
  logic             escape_r, escape_nxt;
  logic             overlong_r, overlong_nxt;
  logic [CNT_W-1:0] raw_count_r, raw_count_nxt;
  logic [CNT_W-1:0] dec_count_r, dec_count_nxt;
  logic             good;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      escape_r     <= 1'b0;
      overlong_r   <= 1'b0;
      raw_count_r  <= '0;
      dec_count_r  <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      escape_r     <= escape_nxt;
      overlong_r   <= overlong_nxt;
      raw_count_r  <= raw_count_nxt;
      dec_count_r  <= dec_count_nxt;
    end
  end

  assign good = !escape_r && !overlong_r &&
                (bsd_pkg::LEN_W'(raw_count_r) <= cfg.max_raw_length);

  assign ram_waddr = dec_count_r[AW-1:0];
  assign cmd.count = bsd_pkg::LEN_W'(dec_count_r);
  assign cmd.id_en = cfg.id_enable;

  always_comb begin
    frame_open_nxt = frame_open_r;
    escape_nxt     = escape_r;
    overlong_nxt   = overlong_r;
    raw_count_nxt  = raw_count_r;
    dec_count_nxt  = dec_count_r;
    ram_we         = 1'b0;
    ram_wdata      = rx_byte;
    cmd_push       = 1'b0;
    if (accept) begin
      if (rx_byte == cfg.start_code) begin
        // A start byte always opens a fresh frame, dropping any partial one.
        frame_open_nxt = 1'b1;
        escape_nxt     = 1'b0;
        overlong_nxt   = 1'b0;
        raw_count_nxt  = CNT_W'(1);
        dec_count_nxt  = '0;
      end else if (frame_open_r) begin
        if (rx_byte == cfg.stop_code) begin
          frame_open_nxt = 1'b0;
          escape_nxt     = 1'b0;
          cmd_push       = good && !(cfg.id_enable && (dec_count_r == '0));
        end else if (raw_count_r >= MAX_CNT) begin
          overlong_nxt = 1'b1;
          escape_nxt   = 1'b0;
        end else begin
          raw_count_nxt = raw_count_r + CNT_W'(1);
          if (escape_r) begin
            escape_nxt = 1'b0;
            ram_wdata  = rx_byte - bsd_pkg::ESC_OFFSET;
            if (dec_count_r < MAX_CNT) begin
              ram_we        = 1'b1;
              dec_count_nxt = dec_count_r + CNT_W'(1);
            end
          end else if (rx_byte == cfg.escape_code) begin
            escape_nxt = 1'b1;
          end else if (dec_count_r < MAX_CNT) begin
            ram_we        = 1'b1;
            dec_count_nxt = dec_count_r + CNT_W'(1);
          end
        end
      end
    end
  end

  // Each stored byte consumed one raw byte after the start byte.
  a_counts_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> (raw_count_r != '0) && (dec_count_r < raw_count_r))
    else $error("decoded count not below raw count in an open frame");

endmodule

`default_nettype wire

@@ rtl/bsd_cmd_q.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on bsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsd_cmd_q (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bsd_pkg::bsd_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic                   full,
  output bsd_pkg::bsd_cmd_t      head
);

  bsd_pkg::bsd_cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign not_empty = (fill_r != 2'd0);
  assign full      = (fill_r == 2'd2);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into a full queue");

endmodule

`default_nettype wire

@@ rtl/bsd_back.sv @@
// Back end: takes frame commands, reads the payload RAM and delivers one
// result per payload byte (or one empty result) through an output register.
// Depends on bsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsd_back #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cmd_valid,
  input  wire bsd_pkg::bsd_cmd_t           cmd,
  output logic                             cmd_pop,
  output logic [$clog2(MAX_FRAME)-1:0]     ram_raddr,
  input  wire logic [bsd_pkg::BYTE_W-1:0]  ram_rdata,
  output logic                             busy,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bsd_pkg::BYTE_W-1:0]       out_payload_byte,
  output logic [bsd_pkg::BYTE_W-1:0]       out_frame_id,
  output logic                             out_byte_present,
  output logic                             out_last_of_frame
);

  localparam int AW = $clog2(MAX_FRAME);

  bsd_pkg::bsd_back_state_t state_r, state_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [bsd_pkg::LEN_W-1:0]    remain_r, remain_nxt;
  logic                         id_pend_r, id_pend_nxt;
  logic [bsd_pkg::BYTE_W-1:0]   id_r, id_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bsd_pkg::BYTE_W-1:0]   payload_r, payload_nxt;
  logic [bsd_pkg::BYTE_W-1:0]   fid_r, fid_nxt;
  logic                         present_r, present_nxt;
  logic                         last_r, last_nxt;
  logic                         slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      id_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      id_pend_r   <= id_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    remain_r  <= remain_nxt;
    id_r      <= id_nxt;
    payload_r <= payload_nxt;
    fid_r     <= fid_nxt;
    present_r <= present_nxt;
    last_r    <= last_nxt;
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign ram_raddr = idx_r;
  assign busy      = (state_r != bsd_pkg::BK_IDLE);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    remain_nxt    = remain_r;
    id_pend_nxt   = id_pend_r;
    id_nxt        = id_r;
    cmd_pop       = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    payload_nxt   = payload_r;
    fid_nxt       = fid_r;
    present_nxt   = present_r;
    last_nxt      = last_r;
    case (state_r)
      bsd_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          idx_nxt     = '0;
          remain_nxt  = cmd.count - bsd_pkg::LEN_W'(cmd.id_en);
          id_pend_nxt = cmd.id_en;
          id_nxt      = '0;
          state_nxt   = bsd_pkg::BK_FETCH;
        end
      end
      // RAM read data for idx_r is valid in the state that follows.
      bsd_pkg::BK_FETCH: begin
        state_nxt = id_pend_r ? bsd_pkg::BK_ID : bsd_pkg::BK_EMIT;
      end
      bsd_pkg::BK_ID: begin
        id_nxt      = ram_rdata;
        id_pend_nxt = 1'b0;
        idx_nxt     = AW'(1);
        state_nxt   = bsd_pkg::BK_FETCH;
      end
      bsd_pkg::BK_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          fid_nxt       = id_r;
          present_nxt   = (remain_r != '0);
          payload_nxt   = (remain_r != '0) ? ram_rdata : '0;
          last_nxt      = (remain_r <= bsd_pkg::LEN_W'(1));
          if (remain_r <= bsd_pkg::LEN_W'(1)) begin
            state_nxt = bsd_pkg::BK_IDLE;
          end else begin
            idx_nxt    = idx_r + AW'(1);
            remain_nxt = remain_r - bsd_pkg::LEN_W'(1);
            state_nxt  = bsd_pkg::BK_FETCH;
          end
        end
      end
      default: begin
        state_nxt = bsd_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = payload_r;
  assign out_frame_id      = fid_r;
  assign out_byte_present  = present_r;
  assign out_last_of_frame = last_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !present_r) |-> last_r)
    else $error("empty-payload result not marked last");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (state_r == bsd_pkg::BK_FETCH))
    else $error("command taken without starting a fetch");

endmodule

`default_nettype wire

@@ rtl/byte_stuffing_deframer.sv @@
// Top level of the byte-stuffing deframer: configuration registers, front
// end, command queue, payload RAM and back end.
// Depends on bsd_pkg, bsd_front, bsd_cmd_q, bsd_ram, bsd_back.
//
//   Port group | Direction | Handshake          | Carries
//   in_*       | input     | in_valid/in_stall  | rx_byte, one raw line byte
//   out_*      | output    | out_valid/out_stall| payload_byte, frame_id, flags
//   cfg_*      | input     | cfg_valid/cfg_ready| register index and write data
//
// A raw byte is taken while no frame command is queued or being delivered.
// After a good stop byte, in_stall stays high while the back end takes the
// command, reads any frame id, then per result a RAM read plus output load.
// Reset is synchronous and clears control state, not the payload RAM.
// out_stall only holds the output register and the back-end sequencer.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffing_deframer #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bsd_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bsd_pkg::BYTE_W-1:0]            out_payload_byte,
  output logic [bsd_pkg::BYTE_W-1:0]            out_frame_id,
  output logic                                  out_byte_present,
  output logic                                  out_last_of_frame,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bsd_pkg::BYTE_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_FRAME);

  bsd_pkg::bsd_cfg_t cfg_r, cfg_nxt;
  bsd_pkg::bsd_cmd_t push_cmd, head_cmd;

  logic                       in_accept;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [bsd_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
  logic                       cmd_push, cmd_pop, q_not_empty, q_full;
  logic                       back_busy;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        bsd_pkg::REG_START_CODE:  cfg_nxt.start_code     = cfg_data;
        bsd_pkg::REG_STOP_CODE:   cfg_nxt.stop_code      = cfg_data;
        bsd_pkg::REG_ESCAPE_CODE: cfg_nxt.escape_code    = cfg_data;
        bsd_pkg::REG_ID_ENABLE:   cfg_nxt.id_enable      = cfg_data[0];
        bsd_pkg::REG_MAX_RAW_LEN: cfg_nxt.max_raw_length = cfg_data[bsd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code     <= bsd_pkg::RST_START_CODE;
      cfg_r.stop_code      <= bsd_pkg::RST_STOP_CODE;
      cfg_r.escape_code    <= bsd_pkg::RST_ESCAPE_CODE;
      cfg_r.id_enable      <= 1'b0;
      cfg_r.max_raw_length <= bsd_pkg::RST_MAX_RAW_LEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The payload RAM is shared, so new bytes wait while a frame drains.
  assign in_stall  = q_not_empty || back_busy;
  assign in_accept = in_valid && !in_stall;

  bsd_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (in_accept),
    .rx_byte  (in_rx_byte),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  bsd_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .not_empty(q_not_empty),
    .full     (q_full),
    .head     (head_cmd)
  );

  bsd_ram #(
    .WIDTH(bsd_pkg::BYTE_W),
    .DEPTH(MAX_FRAME)
  ) u_payload_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bsd_back #(
    .MAX_FRAME(MAX_FRAME)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_not_empty),
    .cmd              (head_cmd),
    .cmd_pop          (cmd_pop),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .busy             (back_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_id     (out_frame_id),
    .out_byte_present (out_byte_present),
    .out_last_of_frame(out_last_of_frame)
  );

  a_no_write_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> !ram_we)
    else $error("payload RAM written while a frame is being read");

  a_queue_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    !q_full)
    else $error("command queue filled up");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for byte_stuffing_deframer: directed and random
// line bytes under several register settings, checked against a frame predictor.
// Depends on bsd_pkg and the byte_stuffing_deframer RTL.
`timescale 1ns / 1ps

module tb_top;
  import bsd_pkg::*;

  localparam int MAX_FRAME   = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET       = 16;

  // Start, stop and escape bytes used by the directed frame-id frames.
  localparam logic [BYTE_W-1:0] ID_START = 8'd255;
  localparam logic [BYTE_W-1:0] ID_STOP  = 8'd0;
  localparam logic [BYTE_W-1:0] ID_ESC   = 8'd128;

  localparam logic [BYTE_W-1:0] DIR_RESET_CODES [21] = '{
    RST_STOP_CODE, RST_ESCAPE_CODE,
    RST_START_CODE, RST_STOP_CODE,
    RST_START_CODE, 8'd0, 8'd255, RST_ESCAPE_CODE, 8'd0,
    RST_ESCAPE_CODE, RST_ESCAPE_CODE, RST_STOP_CODE,
    RST_START_CODE, RST_ESCAPE_CODE, RST_STOP_CODE,
    RST_START_CODE, 8'd9, RST_ESCAPE_CODE, RST_START_CODE, 8'd4, RST_STOP_CODE
  };

  localparam logic [BYTE_W-1:0] DIR_ID_FRAMES [14] = '{
    ID_START, ID_STOP,
    ID_START, 8'd7, ID_STOP,
    ID_START, 8'd7, 8'd8, ID_STOP,
    ID_START, 8'd7, 8'd8, 8'd9, ID_STOP
  };

  typedef struct packed {
    logic [BYTE_W-1:0] payload;
    logic [BYTE_W-1:0] id;
    logic              present;
    logic              last;
  } deframed_t;

  class frame_scoreboard;
    bsd_cfg_t          cfg;
    logic [BYTE_W-1:0] store [MAX_FRAME];
    bit                frame_open;
    bit                esc_pending;
    bit                overlong;
    int unsigned       raw_count;
    int unsigned       decoded_count;
    deframed_t         expected_q [$];
    int                mismatches;
    int                checked;

    function new();
      cfg.start_code     = RST_START_CODE;
      cfg.stop_code      = RST_STOP_CODE;
      cfg.escape_code    = RST_ESCAPE_CODE;
      cfg.id_enable      = 1'b0;
      cfg.max_raw_length = RST_MAX_RAW_LEN;
      frame_open    = 1'b0;
      esc_pending   = 1'b0;
      overlong      = 1'b0;
      raw_count     = 0;
      decoded_count = 0;
      mismatches    = 0;
      checked       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      case (idx)
        REG_START_CODE:  cfg.start_code     = data;
        REG_STOP_CODE:   cfg.stop_code      = data;
        REG_ESCAPE_CODE: cfg.escape_code    = data;
        REG_ID_ENABLE:   cfg.id_enable      = data[0];
        REG_MAX_RAW_LEN: cfg.max_raw_length = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the frame state by one line byte and queues the results it releases.
    function void note_byte(logic [BYTE_W-1:0] b);
      int unsigned       first;
      int unsigned       n;
      logic [BYTE_W-1:0] id;
      bit                good;
      deframed_t         r;
      if (b == cfg.start_code) begin
        frame_open    = 1'b1;
        esc_pending   = 1'b0;
        raw_count     = 1;
        decoded_count = 0;
        overlong      = 1'b0;
        return;
      end
      if (!frame_open) return;
      if (b == cfg.stop_code) begin
        good = !esc_pending && !overlong && raw_count <= 32'(cfg.max_raw_length);
        frame_open  = 1'b0;
        esc_pending = 1'b0;
        if (!good) return;
        first = 0;
        id    = '0;
        if (cfg.id_enable) begin
          if (decoded_count == 0) return;
          id    = store[0];
          first = 1;
        end
        n = decoded_count - first;
        if (n == 0) begin
          r = '{payload: '0, id: id, present: 1'b0, last: 1'b1};
          expected_q.push_back(r);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            r = '{payload: store[first + i], id: id, present: 1'b1, last: (i + 1 == n)};
            expected_q.push_back(r);
          end
        end
        return;
      end
      // Bytes past the physical store length mark the frame as too long.
      if (raw_count >= MAX_FRAME) begin
        overlong    = 1'b1;
        esc_pending = 1'b0;
        return;
      end
      raw_count++;
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (decoded_count < MAX_FRAME) begin
          store[decoded_count] = b - ESC_OFFSET;
          decoded_count++;
        end
      end else if (b == cfg.escape_code) begin
        esc_pending = 1'b1;
      end else if (decoded_count < MAX_FRAME) begin
        store[decoded_count] = b;
        decoded_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [BYTE_W-1:0] payload, logic [BYTE_W-1:0] id,
                      logic present, logic last);
      deframed_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result payload=%0d id=%0d present=%0b last=%0b",
                                  payload, id, present, last));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (payload !== want.payload)
        report_mismatch($sformatf("payload_byte %0d, expected %0d", payload, want.payload));
      if (id !== want.id)
        report_mismatch($sformatf("frame_id %0d, expected %0d", id, want.id));
      if (present !== want.present)
        report_mismatch($sformatf("byte_present %0b, expected %0b", present, want.present));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_frame %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [BYTE_W-1:0]    out_frame_id;
  logic                 out_byte_present;
  logic                 out_last_of_frame;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  frame_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int bytes_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  byte_stuffing_deframer #(.MAX_FRAME(MAX_FRAME)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_frame_id      (out_frame_id),
    .out_byte_present  (out_byte_present),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout: no completion within %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check every transfer, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_payload_byte, out_frame_id, out_byte_present, out_last_of_frame);
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  function automatic logic [BYTE_W-1:0] other_byte(logic [BYTE_W-1:0] a,
                                                   logic [BYTE_W-1:0] b,
                                                   logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == b || v == c);
    return v;
  endfunction

  task automatic send_byte(logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < send_idle) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'($urandom_range(255));
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Waits until every expected result has arrived and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Writes all registers; unused upper data bits and an unused index get noise.
  task automatic apply_setting(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] p,
                               logic [BYTE_W-1:0] e, logic id_en, logic [LEN_W-1:0] len);
    write_reg(CFG_IDX_W'($urandom_range(REG_MAX_RAW_LEN + 1, 2**CFG_IDX_W - 1)),
              8'($urandom_range(255)));
    write_reg(REG_START_CODE, s);
    write_reg(REG_STOP_CODE, p);
    write_reg(REG_ESCAPE_CODE, e);
    write_reg(REG_ID_ENABLE, {7'($urandom_range(127)), id_en});
    write_reg(REG_MAX_RAW_LEN, {1'($urandom_range(1)), len});
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // A well-formed frame; the raw length is mostly short, sometimes near the limit or past the store size.
  task automatic send_frame();
    int unsigned lim;
    int unsigned len;
    int unsigned raw_sent;
    int unsigned r;
    r   = $urandom_range(99);
    lim = (sb.cfg.max_raw_length > MAX_FRAME) ? MAX_FRAME : 32'(sb.cfg.max_raw_length);
    if (r < 70)
      len = $urandom_range(0, 8);
    else if (r < 88)
      len = $urandom_range(9, 20);
    else if (r < 94)
      len = MAX_FRAME + $urandom_range(0, 6);
    else
      len = (lim < 2) ? $urandom_range(0, 2) : lim - 2 + $urandom_range(0, 2);
    send_byte(sb.cfg.start_code);
    raw_sent = 0;
    while (raw_sent < len) begin
      if ($urandom_range(4) == 0 && raw_sent + 2 <= len) begin
        send_byte(sb.cfg.escape_code);
        send_byte(other_byte(sb.cfg.start_code, sb.cfg.stop_code, sb.cfg.stop_code));
        raw_sent += 2;
      end else begin
        send_byte(other_byte(sb.cfg.start_code, sb.cfg.stop_code, sb.cfg.escape_code));
        raw_sent++;
      end
    end
    send_byte(sb.cfg.stop_code);
  endtask

  // Line noise and broken frames.
  task automatic send_noise();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    end else if (r < 40) begin
      send_byte(sb.cfg.stop_code);
    end else if (r < 65) begin
      send_byte(sb.cfg.start_code);
      repeat ($urandom_range(0, 3))
        send_byte(other_byte(sb.cfg.start_code, sb.cfg.stop_code, sb.cfg.escape_code));
      send_byte(sb.cfg.escape_code);
      send_byte(sb.cfg.stop_code);
    end else if (r < 85) begin
      send_byte(sb.cfg.start_code);
      repeat ($urandom_range(1, 5))
        send_byte(other_byte(sb.cfg.start_code, sb.cfg.stop_code, sb.cfg.escape_code));
    end else begin
      send_byte(sb.cfg.start_code);
      repeat (3) send_byte(sb.cfg.escape_code);
      send_byte(other_byte(sb.cfg.start_code, sb.cfg.stop_code, sb.cfg.escape_code));
      send_byte(sb.cfg.stop_code);
    end
  endtask

  task automatic run_random(int items);
    int target;
    target = bytes_sent + items;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 80) send_frame();
      else send_noise();
    end
    drain();
  endtask

  task automatic random_setting(logic id_en, logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] p;
    logic [BYTE_W-1:0] e;
    s = 8'($urandom_range(255));
    p = other_byte(s, s, s);
    e = other_byte(s, p, p);
    apply_setting(s, p, e, id_en, len);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 18;
    recv_idle = 64;
    foreach (DIR_RESET_CODES[i]) send_byte(DIR_RESET_CODES[i]);
    drain();
    apply_setting(ID_START, ID_STOP, ID_ESC, 1'b1, 7'd3);
    foreach (DIR_ID_FRAMES[i]) send_byte(DIR_ID_FRAMES[i]);
    drain();

    random_setting(1'b0, 7'd64);
    run_random(20);
    // With a limit of one only empty frames pass.
    random_setting(1'b0, 7'd1);
    run_random(20);

    send_idle = 64;
    recv_idle = 18;
    random_setting(1'b1, 7'd10);
    run_random(20);
    // Limits above the store size behave as the store size.
    random_setting(1'b0, 7'd127);
    run_random(20);

    send_idle = 0;
    recv_idle = 0;
    apply_setting(8'd0, 8'd255, other_byte(8'd0, 8'd255, 8'd255), 1'b1, 7'd64);
    run_random(20);
    random_setting(1'b0, 7'd2);
    run_random(15);
    random_setting(1'b1, 7'd0);
    run_random(10);

    $display("Sent %0d line bytes under %0d register settings; %0d results checked.",
             bytes_sent, settings_applied, sb.checked);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found.", sb.mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bsd_pkg.sv
rtl/bsd_ram.sv
rtl/bsd_front.sv
rtl/bsd_cmd_q.sv
rtl/bsd_back.sv
rtl/byte_stuffing_deframer.sv
verif/tb_top.sv
